### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int DATA_W   = 32;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;       // execute the accepted request and load its first result
    logic dump_next;  // load the next dump entry into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_multi; // the offered request is a dump of more than one entry
    logic dump_final; // the next dump entry to load is the final one
  } dp_status_t;

endpackage

### rtl/ple_ctrl.sv
`include "assert_macros.svh"

module ple_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ple_pkg::dp_status_t st,
  output ple_pkg::ctrl_cmd_t  ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic can_load;
  logic accept;

  // The output register can take a new result when empty or being drained.
  assign can_load = !out_valid || !out_stall;
  assign in_stall = (state == S_DUMP) || !can_load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    ctl.exec       = accept;
    ctl.dump_next  = 1'b0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          out_valid_next = 1'b1;
          if (st.dump_multi) begin
            state_next = S_DUMP;
          end
        end
      end
      S_DUMP: begin
        if (can_load) begin
          ctl.dump_next  = 1'b1;
          out_valid_next = 1'b1;
          if (st.dump_final) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_IMPL(a_dump_holds_result, clk, rst, state == S_DUMP, out_valid)
  `ASSERT_NEXT(a_accept_loads_result, clk, rst, accept, out_valid)
  `ASSERT_NEXT(a_final_entry_ends_dump, clk, rst, ctl.dump_next && st.dump_final,
               state == S_IDLE)

endmodule

### rtl/ple_cells.sv
module ple_cells #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ple_pkg::CMD_W-1:0]           cmd,
  input  logic signed [ple_pkg::DATA_W-1:0]   value,
  input  logic [ple_pkg::POS_W-1:0]           position,
  input  ple_pkg::ctrl_cmd_t                  ctl,
  output ple_pkg::dp_status_t                 st,
  output logic [ple_pkg::STATUS_W-1:0]        status,
  output logic [ple_pkg::COUNT_W-1:0]         entry_count,
  output logic signed [ple_pkg::DATA_W-1:0]   entry_value,
  output logic                                entry_valid,
  output logic                                last
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW0 = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int PW  = PW0 + 1;

  logic [VALUE_BITS-1:0] cells [CAPACITY];
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;

  logic [PW-1:0]                 cnt_w;
  logic [PW-1:0]                 pos_w;
  logic [PW-1:0]                 p;
  logic [PW-1:0]                 cnt_after;
  logic                          do_ins;
  logic                          do_del;
  logic                          is_dump;
  logic                          full;
  logic                          empty;
  logic [ple_pkg::STATUS_W-1:0]  op_st;
  logic signed [63:0]            v64;
  logic [VALUE_BITS-1:0]         vin;
  logic [IW-1:0]                 rd_idx;
  logic signed [VALUE_BITS-1:0]  rword;
  logic signed [63:0]            r64;
  logic [ple_pkg::DATA_W-1:0]    rd;

  assign cnt_w = PW'(count);
  assign pos_w = PW'(position);
  assign full  = (cnt_w >= PW'(CAPACITY));
  assign empty = (count == '0);

  // The insert word is kept in VALUE_BITS bits, two's complement.
  assign v64 = 64'(value);
  assign vin = v64[VALUE_BITS-1:0];

  always_comb begin
    op_st   = ple_pkg::ST_OK;
    p       = '0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    is_dump = 1'b0;
    case (cmd)
      ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_AT: begin
        if (full) begin
          op_st = ple_pkg::ST_FULL;
        end else if (cmd == ple_pkg::CMD_INS_FRONT) begin
          do_ins = 1'b1;
        end else if (cmd == ple_pkg::CMD_INS_BACK) begin
          do_ins = 1'b1;
          p      = cnt_w;
        end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
          op_st = ple_pkg::ST_BADPOS;
        end else begin
          do_ins = 1'b1;
          p      = pos_w - PW'(1);
        end
      end
      ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK, ple_pkg::CMD_DEL_AT: begin
        if (empty) begin
          op_st = ple_pkg::ST_EMPTY;
        end else if (cmd == ple_pkg::CMD_DEL_FRONT) begin
          do_del = 1'b1;
        end else if (cmd == ple_pkg::CMD_DEL_BACK) begin
          do_del = 1'b1;
          p      = cnt_w - PW'(1);
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          op_st = ple_pkg::ST_BADPOS;
        end else begin
          do_del = 1'b1;
          p      = pos_w - PW'(1);
        end
      end
      ple_pkg::CMD_DUMP: begin
        is_dump = 1'b1;
      end
      default: begin
        op_st = ple_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    cnt_after = cnt_w;
    if (do_ins) begin
      cnt_after = cnt_w + PW'(1);
    end else if (do_del) begin
      cnt_after = cnt_w - PW'(1);
    end
  end

  // Cells from the position upward shift in parallel: up for an insert, down for a delete.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int GL = (g > 0) ? g - 1 : 0;
    localparam int GH = (g < CAPACITY - 1) ? g + 1 : g;
    always_ff @(posedge clk) begin
      if (ctl.exec && do_ins) begin
        if (PW'(g) == p) begin
          cells[g] <= vin;
        end else if (PW'(g) > p) begin
          cells[g] <= cells[GL];
        end
      end else if (ctl.exec && do_del) begin
        if (PW'(g) >= p) begin
          cells[g] <= cells[GH];
        end
      end
    end
  end

  // Dump read port: entry zero on the request itself, then the walking index.
  assign rd_idx = ctl.exec ? '0 : idx[IW-1:0];
  assign rword  = cells[rd_idx];
  assign r64    = 64'(rword);
  assign rd     = r64[ple_pkg::DATA_W-1:0];

  assign st.dump_multi = is_dump && (cnt_w > PW'(1));
  assign st.dump_final = ((PW'(idx) + PW'(1)) == cnt_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.exec) begin
      count <= cnt_after[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      status      <= op_st;
      entry_count <= cnt_after[ple_pkg::COUNT_W-1:0];
      entry_valid <= is_dump && !empty;
      entry_value <= (is_dump && !empty) ? rd : '0;
      last        <= !(is_dump && (cnt_w > PW'(1)));
      idx         <= CW'(1);
    end else if (ctl.dump_next) begin
      status      <= ple_pkg::ST_OK;
      entry_valid <= 1'b1;
      entry_value <= rd;
      last        <= st.dump_final;
      idx         <= idx + CW'(1);
    end
  end

endmodule

### rtl/positional_list_engine_top.sv
// Positional list engine: an ordered list of up to CAPACITY signed words.
// The input channel (in_valid, in_stall, cmd, value, position) takes one
// request per command: insert at the front, back or a 1-based position,
// delete at the front, back or a 1-based position, or dump the list.
// The output channel (out_valid, out_stall, status, entry_count,
// entry_value, entry_valid, last) returns the results of each request.
// Inserts, deletes and ignored codes give one result; a dump gives one
// result per entry (one empty result for an empty list), last marking the
// final one. Every result carries the status and the count afterwards.
// A request's first result is valid in the cycle after its accept.
// Non-dump requests are taken one per cycle while results are taken, since
// the cells shift in parallel; a dump returns one entry a cycle while
// results are taken, and keeps in_stall high until its final entry loads.
// The output register frees up as it drains, so a new request can be taken
// in the cycle its predecessor's result leaves. When out_stall is high the
// result holds and in_stall rises once the output register is occupied.
// Synchronous reset empties the list and drops any pending result; cell
// contents are not cleared and are never read before they are written.
module positional_list_engine_top #(
  parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = ple_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ple_pkg::CMD_W-1:0]           cmd,
  input  logic signed [ple_pkg::DATA_W-1:0]   value,
  input  logic [ple_pkg::POS_W-1:0]           position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ple_pkg::STATUS_W-1:0]        status,
  output logic [ple_pkg::COUNT_W-1:0]         entry_count,
  output logic signed [ple_pkg::DATA_W-1:0]   entry_value,
  output logic                                entry_valid,
  output logic                                last
);

  // Command and status groups between the controller and the datapath.
  ple_pkg::ctrl_cmd_t  ctl;
  ple_pkg::dp_status_t st;

  // The controller owns the handshakes and the dump sequencing.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl)
  );

  // The datapath holds the cells, the count and the output register.
  ple_cells #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_cells (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (value),
    .position    (position),
    .ctl         (ctl),
    .st          (st),
    .status      (status),
    .entry_count (entry_count),
    .entry_value (entry_value),
    .entry_valid (entry_valid),
    .last        (last)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the positional list engine. Requests (insert,
// delete, dump) are pushed through the input channel. Each accepted request
// is applied to a queue-based copy of the list, which yields the results the
// block must return. The output monitor compares every accepted result,
// field by field, against the oldest prediction.
module tb_top;

  localparam int LIST_CAPACITY = ple_pkg::CAPACITY_DEF;

  typedef logic [ple_pkg::CMD_W-1:0]   cmd_t;
  typedef logic [ple_pkg::POS_W-1:0]   pos_t;
  typedef logic [ple_pkg::COUNT_W-1:0] count_t;

  // Code 7 is not a command. The block must answer it with a plain ok result.
  localparam cmd_t CMD_UNUSED = 3'd7;

  // One result as it appears on the output channel.
  typedef struct packed {
    logic [ple_pkg::STATUS_W-1:0] status;
    logic [ple_pkg::COUNT_W-1:0]  count;
    logic [ple_pkg::DATA_W-1:0]   word;
    logic                         valid;
    logic                         last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ple_pkg::CMD_W-1:0]         cmd = '0;
  logic signed [ple_pkg::DATA_W-1:0] value = '0;
  logic [ple_pkg::POS_W-1:0]         position = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [ple_pkg::STATUS_W-1:0]      status;
  logic [ple_pkg::COUNT_W-1:0]       entry_count;
  logic signed [ple_pkg::DATA_W-1:0] entry_value;
  logic                              entry_valid;
  logic                              last;

  // Our own copy of the list, oldest entry at index 0, and the results
  // that the block still owes us, in order.
  logic signed [ple_pkg::DATA_W-1:0] list_words[$];
  list_result_t                      expected_results[$];

  int mismatch_count = 0;

  // Idle and stall rates, in percent per cycle. The long hold-off on the
  // output side is requested through hold_cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;

  positional_list_engine_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .entry_value (entry_value),
    .entry_valid (entry_valid),
    .last        (last)
  );

  always #5 clk = ~clk;

  // Applies one accepted request to the list copy and queues the results
  // it must produce. Inserts are refused on a full list before the position
  // is looked at, and deletes on an empty list likewise. A valid insert
  // position runs from 1 to count+1, a valid delete position from 1 to count.
  function automatic void predict_list_op(input cmd_t op,
                                          input logic signed [ple_pkg::DATA_W-1:0] word,
                                          input pos_t pos);
    logic [ple_pkg::STATUS_W-1:0] st;
    list_result_t                 res;
    int                           n;
    st = ple_pkg::ST_OK;
    n  = list_words.size();
    case (op)
      ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK, ple_pkg::CMD_INS_AT: begin
        if (n >= LIST_CAPACITY) st = ple_pkg::ST_FULL;
        else if (op == ple_pkg::CMD_INS_FRONT) list_words.push_front(word);
        else if (op == ple_pkg::CMD_INS_BACK) list_words.push_back(word);
        else if (pos < 1 || pos > n + 1) st = ple_pkg::ST_BADPOS;
        else list_words.insert(pos - 1, word);
      end
      ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK, ple_pkg::CMD_DEL_AT: begin
        if (n == 0) st = ple_pkg::ST_EMPTY;
        else if (op == ple_pkg::CMD_DEL_FRONT) list_words.delete(0);
        else if (op == ple_pkg::CMD_DEL_BACK) list_words.delete(n - 1);
        else if (pos < 1 || pos > n) st = ple_pkg::ST_BADPOS;
        else list_words.delete(pos - 1);
      end
      ple_pkg::CMD_DUMP: begin
        // A non-empty list comes out one entry per result. An empty list
        // falls through to the single plain result below.
        if (n > 0) begin
          for (int i = 0; i < n; i++) begin
            res = {ple_pkg::ST_OK, count_t'(n), list_words[i], 1'b1, 1'b0};
            res.last = (i == n - 1);
            expected_results.push_back(res);
          end
          return;
        end
      end
      default: ;
    endcase
    res = {st, count_t'(list_words.size()), {ple_pkg::DATA_W{1'b0}}, 1'b0, 1'b1};
    expected_results.push_back(res);
  endfunction

  // Offers one request, idling first at the current rate. Valid stays high
  // after acceptance, so the next call can follow without a gap. in_stall is
  // sampled at the falling edge, where everything is settled, and the request
  // counts as taken at the rising edge that follows.
  task automatic send_request(input cmd_t op,
                              input logic signed [ple_pkg::DATA_W-1:0] word,
                              input pos_t pos);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= word;
    position <= pos;
    do begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end while (!taken);
    predict_list_op(op, word, pos);
  endtask

  task automatic note_mismatch(input string what, input list_result_t want,
                               input list_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"%0t %s: expected st %0d cnt %0d val %0d vld %0d last %0d,",
                " got st %0d cnt %0d val %0d vld %0d last %0d"},
               $realtime, what, want.status, want.count, $signed(want.word),
               want.valid, want.last, got.status, got.count, $signed(got.word),
               got.valid, got.last);
  endtask

  // The output side. A long hold-off, when one is requested, takes priority
  // over the random stalls.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker. Like the sender, it samples at the falling edge, and a
  // result seen there is taken at the next rising edge.
  always @(negedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = {status, entry_count, entry_value, entry_valid, last};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", got, got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) note_mismatch("result mismatch", want, got);
      end
    end
  end

  // Random values that now and then land on the extremes.
  function automatic logic signed [ple_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // The empty list. Deletes are refused with the empty status even at a
  // position that would be invalid anyway. Dump and the unused code give a
  // single plain result.
  task automatic test_empty_list();
    send_request(ple_pkg::CMD_DUMP, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_FRONT, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_BACK, pick_word(), 7'd1);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd1);
    send_request(CMD_UNUSED, pick_word(), 7'd127);
  endtask

  // Every insert command, with positions at and just beyond both ends.
  task automatic test_insert_positions();
    send_request(ple_pkg::CMD_INS_AT, 32'sd5, 7'd0);
    send_request(ple_pkg::CMD_INS_AT, 32'sd6, 7'd2);
    send_request(ple_pkg::CMD_INS_AT, 32'sh7FFF_FFFF, 7'd1);
    send_request(ple_pkg::CMD_INS_BACK, 32'sh8000_0000, 7'd0);
    send_request(ple_pkg::CMD_INS_FRONT, 32'sd0, 7'd127);
    send_request(ple_pkg::CMD_INS_AT, -32'sd1, 7'd4);
    send_request(ple_pkg::CMD_INS_AT, 32'sh5555_5555, 7'd2);
    send_request(ple_pkg::CMD_INS_AT, 32'sh2AAA_AAAA, 7'd127);
    send_request(ple_pkg::CMD_DUMP, 32'sd0, 7'd0);
  endtask

  // Every delete command on the five entries left by the insert test, down
  // to an empty list.
  task automatic test_delete_positions();
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd6);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd5);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd2);
    send_request(ple_pkg::CMD_DEL_FRONT, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_BACK, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DUMP, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd1);
    send_request(ple_pkg::CMD_DUMP, pick_word(), 7'd0);
  endtask

  // Fill to capacity at random positions, check that a full list refuses
  // every insert (the full status wins over a bad position), dump all
  // entries, then drain at random positions.
  task automatic test_full_list();
    while (list_words.size() < LIST_CAPACITY)
      send_request(ple_pkg::CMD_INS_AT, pick_word(),
                   pos_t'($urandom_range(list_words.size() + 1, 1)));
    send_request(ple_pkg::CMD_INS_FRONT, pick_word(), 7'd1);
    send_request(ple_pkg::CMD_INS_AT, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_INS_BACK, pick_word(), 7'd17);
    send_request(ple_pkg::CMD_DUMP, pick_word(), 7'd0);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd17);
    send_request(ple_pkg::CMD_DEL_AT, pick_word(), 7'd16);
    send_request(ple_pkg::CMD_INS_AT, pick_word(), 7'd16);
    send_request(ple_pkg::CMD_DUMP, pick_word(), 7'd0);
    while (list_words.size() > 0)
      send_request(ple_pkg::CMD_DEL_AT, pick_word(),
                   pos_t'($urandom_range(list_words.size(), 1)));
    send_request(ple_pkg::CMD_DEL_BACK, pick_word(), 7'd0);
  endtask

  // Random traffic. The list drifts toward a target size that changes every
  // twenty requests, so it keeps moving between empty and full. Positions
  // are mostly near the valid range, sometimes anywhere in the field.
  task automatic random_requests(input int n_items);
    int   target;
    int   size;
    int   r;
    bit   grow;
    cmd_t op;
    cmd_t ins_op;
    cmd_t del_op;
    pos_t pos;
    target = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) target = $urandom_range(LIST_CAPACITY);
      size   = list_words.size();
      grow   = (size < target);
      ins_op = ple_pkg::CMD_INS_FRONT + cmd_t'($urandom_range(2));
      del_op = ple_pkg::CMD_DEL_FRONT + cmd_t'($urandom_range(2));
      r      = $urandom_range(99);
      if (r < 8) op = ple_pkg::CMD_DUMP;
      else if (r < 11) op = CMD_UNUSED;
      else if (r < 73) op = grow ? ins_op : del_op;
      else op = grow ? del_op : ins_op;
      if ($urandom_range(99) < 85) pos = pos_t'($urandom_range(size + 1));
      else pos = pos_t'($urandom_range(127));
      send_request(op, pick_word(), pos);
    end
  endtask

  // The output side holds off for a long stretch while the sender keeps
  // offering requests back to back, so the result register fills and the
  // block has to stall its input.
  task automatic test_back_pressure();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_cycles   = 150;
    random_requests(30);
    send_idle_pct = saved_idle;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with a slow receiver.
    send_idle_pct  = 12;
    recv_stall_pct = 67;
    test_empty_list();
    test_insert_positions();
    test_delete_positions();
    test_full_list();

    // Random part in three phases: slow receiver, then slow sender, then
    // both running flat out. The long hold-off sits in the middle.
    random_requests(70);
    send_idle_pct  = 67;
    recv_stall_pct = 12;
    random_requests(70);
    test_back_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_requests(70);
    in_valid <= 1'b0;

    // Drain, then give a stray extra result some time to show up.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog. A correct run needs well under a tenth of this.
  initial begin
    #3ms;
    $display("status: fail");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_ctrl.sv
rtl/ple_cells.sv
rtl/positional_list_engine_top.sv
tb/tb_top.sv
